// ----- src/weekday_alarm_job_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// Weekday alarm job matcher: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef WEEKDAY_ALARM_JOB_MATCHER_MACROS_SVH
`define WEEKDAY_ALARM_JOB_MATCHER_MACROS_SVH

// checked only outside reset
`define WAJM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define WAJM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/wajm_pkg.sv -----
// ----------------------------------------------------------------------------
// Weekday alarm job matcher package
// Field widths, slot layout and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package wajm_pkg;

  localparam int JOB_SLOTS  = 8;
  localparam int MAX_SLOTS  = 8;
  localparam int IDX_W      = 3;
  localparam int SLOT_W     = 19;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int WEEKDAY_W  = 3;
  localparam int DAYS       = 7;
  localparam int FIFO_DEPTH = 4;  // power of two

  localparam int SLOT_EN_BIT  = 18;
  localparam int SLOT_HOUR_LO = 13;
  localparam int SLOT_MIN_LO  = 7;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- src/wajm_fifo.sv -----
// ----------------------------------------------------------------------------
// Fire mask queue
// Small FIFO between the matcher front end and the index emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weekday_alarm_job_matcher_macros.svh"

module wajm_fifo #(
  parameter int Width = wajm_pkg::JOB_SLOTS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [Width-1:0]  push_data_i,
  input  wire logic              pop_i,
  output logic [Width-1:0]       pop_data_o,
  output wajm_pkg::q_status_t    status_o
);

  localparam int Depth = wajm_pkg::FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

  `WAJM_ASSERT(a_no_overflow, push_i |-> !status_o.full, "push into full queue")
  `WAJM_ASSERT(a_no_underflow, pop_i |-> !status_o.empty, "pop from empty queue")
  `WAJM_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CntW'(Depth)), "queue count out of range")

endmodule

`default_nettype wire

// ----- src/wajm_front.sv -----
// ----------------------------------------------------------------------------
// Matcher front end
// Holds the job slots and done flags, matches each check, queues fire masks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weekday_alarm_job_matcher_macros.svh"

module wajm_front #(
  parameter int JobSlots = wajm_pkg::JOB_SLOTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wajm_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [wajm_pkg::SLOT_W-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           time_valid_i,
  input  wire logic [wajm_pkg::HOUR_W-1:0]    hour_now_i,
  input  wire logic [wajm_pkg::MINUTE_W-1:0]  minute_now_i,
  input  wire logic [wajm_pkg::WEEKDAY_W-1:0] weekday_now_i,
  input  wire wajm_pkg::q_status_t            q_status_i,
  output logic                                push_o,
  output logic [JobSlots-1:0]                 push_data_o
);

  logic [wajm_pkg::SLOT_W-1:0] slot_q [JobSlots];
  logic [JobSlots-1:0]         done_q, done_d;
  logic [JobSlots-1:0]         done_eff;
  logic [JobSlots-1:0]         fire;
  logic                        accept;
  logic                        midnight;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign midnight   = (hour_now_i == '0) && (minute_now_i == '0);
  assign done_eff   = midnight ? '0 : done_q;

  always_comb begin
    logic [wajm_pkg::SLOT_W-1:0] s;
    logic [wajm_pkg::DAYS:0]     days;
    for (int i = 0; i < JobSlots; i++) begin
      s    = slot_q[i];
      days = {1'b0, s[wajm_pkg::DAYS-1:0]};
      fire[i] = s[wajm_pkg::SLOT_EN_BIT]
        && !done_eff[i]
        && (s[wajm_pkg::SLOT_EN_BIT-1:wajm_pkg::SLOT_HOUR_LO] == hour_now_i)
        && (s[wajm_pkg::SLOT_HOUR_LO-1:wajm_pkg::SLOT_MIN_LO] == minute_now_i)
        && days[weekday_now_i];
    end
  end

  assign push_o      = accept && time_valid_i && (fire != '0);
  assign push_data_o = fire;

  always_comb begin
    done_d = done_q;
    if (accept && time_valid_i) begin
      done_d = done_eff | fire;
    end
    for (int i = 0; i < JobSlots; i++) begin
      if (cfg_we_i && (cfg_index_i == wajm_pkg::IDX_W'(i))) begin
        done_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      for (int i = 0; i < JobSlots; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      done_q <= done_d;
      for (int i = 0; i < JobSlots; i++) begin
        if (cfg_we_i && (cfg_index_i == wajm_pkg::IDX_W'(i))) begin
          slot_q[i] <= cfg_data_i;
        end
      end
    end
  end

  `WAJM_ASSERT(a_push_nonzero, push_o |-> (push_data_o != '0), "empty fire mask queued")
  `WAJM_ASSERT(a_fire_sets_done, push_o |=> ((done_q & $past(push_data_o)) == $past(push_data_o)),
               "fired slot not marked done")

endmodule

`default_nettype wire

// ----- src/wajm_back.sv -----
// ----------------------------------------------------------------------------
// Index emitter
// Drains each fire mask one slot index per transfer, lowest slot first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weekday_alarm_job_matcher_macros.svh"

module wajm_back #(
  parameter int JobSlots = wajm_pkg::JOB_SLOTS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wajm_pkg::q_status_t         q_status_i,
  input  wire logic [JobSlots-1:0]         pop_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [wajm_pkg::IDX_W-1:0]       job_index_o,
  output logic                             last_fired_o
);

  logic [JobSlots-1:0]          work_q, work_d;
  logic [JobSlots-1:0]          rest;
  logic                         out_valid_q, out_valid_d;
  logic [wajm_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                         last_q, last_d;
  logic [wajm_pkg::IDX_W-1:0]   low_idx;
  logic                         can_load;
  logic                         take;

  always_comb begin
    low_idx = '0;
    for (int i = JobSlots - 1; i >= 0; i--) begin
      if (work_q[i]) begin
        low_idx = wajm_pkg::IDX_W'(i);
      end
    end
  end

  assign rest     = work_q & (work_q - JobSlots'(1));
  assign can_load = !out_valid_q || !out_stall_i;
  assign take     = can_load && (work_q != '0);
  assign pop_o    = !q_status_i.empty && ((work_q == '0) || (take && (rest == '0)));

  always_comb begin
    work_d      = work_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (can_load) begin
      out_valid_d = take;
    end
    if (take) begin
      idx_d  = low_idx;
      last_d = (rest == '0);
      work_d = rest;
    end
    if (pop_o) begin
      work_d = pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign job_index_o  = idx_q;
  assign last_fired_o = last_q;

  `WAJM_ASSERT(a_more_pending, (out_valid_q && !last_q) |-> (work_q != '0),
               "non-final index with nothing left to send")

endmodule

`default_nettype wire

// ----- src/weekday_alarm_job_matcher.sv -----
// ----------------------------------------------------------------------------
// Weekday alarm job matcher
// Matches schedule checks against job slots and emits fired slot indices.
//
//   channel  direction  handshake                 payload
//   check    in         in_valid_i / in_stall_o   time_valid, hour, minute, weekday
//   fired    out        out_valid_o / out_stall_i job_index, last_fired
//   config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A check is matched against all slots in the cycle it is accepted; one check
// per cycle while the fire mask queue has room.
// Indices leave at one per cycle while out_stall_i is low, so a check firing n
// jobs yields n indices (up to JobSlots); a check firing none queues no mask.
// Indices pass through the queue, the work register and the output register.
// Reset clears slots and done flags; out_stall_i backs up into the queue,
// and in_stall_o rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module weekday_alarm_job_matcher #(
  parameter int JobSlots = wajm_pkg::JOB_SLOTS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wajm_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [wajm_pkg::SLOT_W-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           time_valid_i,
  input  wire logic [wajm_pkg::HOUR_W-1:0]    hour_now_i,
  input  wire logic [wajm_pkg::MINUTE_W-1:0]  minute_now_i,
  input  wire logic [wajm_pkg::WEEKDAY_W-1:0] weekday_now_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [wajm_pkg::IDX_W-1:0]          job_index_o,
  output logic                                last_fired_o
);

  wajm_pkg::q_status_t  q_status;
  logic                 push;
  logic [JobSlots-1:0]  push_data;
  logic                 pop;
  logic [JobSlots-1:0]  pop_data;

  assign cfg_ready_o = 1'b1;

  wajm_front #(
    .JobSlots(JobSlots)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .time_valid_i (time_valid_i),
    .hour_now_i   (hour_now_i),
    .minute_now_i (minute_now_i),
    .weekday_now_i(weekday_now_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  wajm_fifo #(
    .Width(JobSlots)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (q_status)
  );

  wajm_back #(
    .JobSlots(JobSlots)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .job_index_o (job_index_o),
    .last_fired_o(last_fired_o)
  );

endmodule

`default_nettype wire
